// ===== hdl/sws_pkg.sv =====
// Package for the sliding window statistics block: widths and defaults.
// No dependencies.
package sws_pkg;
	localparam int unsigned WINDOW_DEF = 16;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned SUBLEN_W   = 8;
	localparam int unsigned FRAC_W     = 17;
	localparam int unsigned QUO_W      = 24;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic {
		ACT_PUSH  = 1'b0,
		ACT_CLEAR = 1'b1
	} action_t;

	// Command from the sequencer to the slot chain
	typedef struct packed {
		logic push;
		logic clear;
		logic rotate;
	} chain_ctrl_t;
endpackage

// ===== hdl/sws_cell.sv =====
// One window slot of the chain: holds a sample, shifts on push, rotates on scan.
// Depends on sws_pkg.
module sws_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sws_pkg::chain_ctrl_t ctrl,
	input  sws_pkg::sample_t    shift_in,
	input  sws_pkg::sample_t    rot_in,
	output sws_pkg::sample_t    value
);
	import sws_pkg::*;

	sample_t slot_q;

	// Slot register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctrl.clear) begin
			slot_q <= '0;
		end else if (ctrl.push) begin
			slot_q <= shift_in;
		end else if (ctrl.rotate) begin
			slot_q <= rot_in;
		end
	end

	assign value = slot_q;
endmodule

// ===== hdl/sws_div.sv =====
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on sws_pkg.
module sws_div #(
	parameter int unsigned NUM_W = 24,
	parameter int unsigned DEN_W = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    busy,
	output logic signed [NUM_W-1:0] quo
);
	import sws_pkg::*;

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] mag_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	// Shift-subtract iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : num;
			neg_q <= num[NUM_W-1];
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff;
				mag_q <= {mag_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				mag_q <= {mag_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = neg_q ? -$signed(mag_q) : $signed(mag_q);
endmodule

// ===== hdl/sliding_window_statistics.sv =====
// Top level of the sliding window statistics block: slot chain, scan, dividers.
// Depends on sws_pkg, sws_cell, sws_div.
//
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | action, sample, sub_length
//  out     | out_valid/out_ready| average .. fill_level
//
// An item is scanned first (the slot chain rotates once past the
// accumulator), then divided in the two dividers running in parallel, and
// then the output register is loaded. Reset clears all slots and the fill count
// at once. A result is held until taken; the next item is accepted while it
// waits, and its scan finishes before the block stalls for the pending result.
// No new item is accepted until the result of the last one is registered.
module sliding_window_statistics #(
	parameter int unsigned WINDOW = sws_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic signed [sws_pkg::SAMPLE_W-1:0] sample,
	input  logic [sws_pkg::SUBLEN_W-1:0]  sub_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [15:0]            average,
	output logic signed [15:0]            maximum,
	output logic signed [15:0]            minimum,
	output logic [sws_pkg::FRAC_W-1:0]    nonzero_fraction,
	output logic signed [15:0]            tail_average,
	output logic                          tail_valid,
	output logic [4:0]                    fill_level
);
	import sws_pkg::*;

	localparam int unsigned IDX_W = $clog2(WINDOW);
	localparam int unsigned CNT_W = $clog2(WINDOW + 1);
	localparam int unsigned DEN_W = CNT_W > SUBLEN_W ? CNT_W : SUBLEN_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIVS = 4'b0100,
		ST_WAIT = 4'b1000
	} state_t;

	state_t           state_q;
	chain_ctrl_t      ctrl;
	sample_t          slot [WINDOW];
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W:0]   step_q;
	logic [SUBLEN_W-1:0] sub_q;
	logic signed [QUO_W-1:0] sum_q, tsum_q;
	sample_t          max_q, min_q;
	logic [CNT_W-1:0] nz_q;
	logic             div_start;
	logic             busy_a, busy_t;
	logic signed [QUO_W-1:0] quo_a, quo_t;
	logic             tvalid;
	logic             res_pend_q;
	logic in_xfer;
	logic [FRAC_W-1:0] frac_lut [WINDOW+1];

	assign in_xfer  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// Chain: push shifts toward slot 0, scan rotates newest-first into slot WINDOW-1
	assign ctrl.push   = in_xfer && (action == ACT_PUSH);
	assign ctrl.clear  = in_xfer && (action == ACT_CLEAR);
	assign ctrl.rotate = (state_q == ST_SCAN) && (step_q != '0);

	for (genvar g = 0; g < WINDOW; g++) begin : g_cell
		sws_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.shift_in (g == WINDOW - 1 ? sample : slot[(g + 1) % WINDOW]),
			.rot_in   (slot[(g + WINDOW - 1) % WINDOW]),
			.value    (slot[g])
		);
	end

	// Constant table of nonzero fractions, one entry per nonzero count
	for (genvar g = 0; g <= WINDOW; g++) begin : g_frac
		assign frac_lut[g] = FRAC_W'((g * 65536) / WINDOW);
	end

	assign tvalid = (sub_q != '0) && (32'(sub_q) <= WINDOW);

	// Sequencer and accumulators; slot WINDOW-1 feeds the accumulators during scan, newest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			step_q     <= '0;
			res_pend_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) res_pend_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_SCAN;
						step_q  <= (IDX_W + 1)'(WINDOW);
						if (action == ACT_CLEAR) fill_q <= '0;
						else if (32'(fill_q) < WINDOW) fill_q <= fill_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (step_q == '0) state_q <= ST_DIVS;
					else step_q <= step_q - 1'b1;
				end
				ST_DIVS: begin
					if (!div_start && !busy_a && !busy_t && !res_pend_q) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					res_pend_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sub_q  <= sub_length;
			sum_q  <= '0;
			tsum_q <= '0;
			nz_q   <= '0;
			max_q  <= ctrl.push ? sample : '0;
			min_q  <= ctrl.push ? sample : '0;
		end else if (ctrl.rotate) begin
			sum_q <= sum_q + QUO_W'(slot[WINDOW-1]);
			if ((IDX_W + 1)'(WINDOW) - step_q < (IDX_W + 1)'(sub_q > SUBLEN_W'(WINDOW) ?
					SUBLEN_W'(WINDOW) : sub_q))
				tsum_q <= tsum_q + QUO_W'(slot[WINDOW-1]);
			if (slot[WINDOW-1] > max_q) max_q <= slot[WINDOW-1];
			if (slot[WINDOW-1] < min_q) min_q <= slot[WINDOW-1];
			if (slot[WINDOW-1] != '0) nz_q <= nz_q + 1'b1;
		end
	end

	assign div_start = (state_q == ST_SCAN) && (step_q == '0);

	sws_div #(.NUM_W(QUO_W), .DEN_W(DEN_W)) u_div_avg (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(sum_q),
		.den(fill_q == '0 ? DEN_W'(1) : DEN_W'(fill_q)), .busy(busy_a), .quo(quo_a)
	);

	sws_div #(.NUM_W(QUO_W), .DEN_W(DEN_W)) u_div_tail (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(tsum_q),
		.den(tvalid ? DEN_W'(sub_q) : DEN_W'(1)), .busy(busy_t), .quo(quo_t)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT) begin
			average <= (fill_q == '0) ? '0 : 16'(quo_a);
			maximum <= max_q;
			minimum <= min_q;
			nonzero_fraction <= frac_lut[nz_q];
			tail_average <= tvalid ? 16'(quo_t) : '0;
			tail_valid <= tvalid;
			fill_level <= 5'(fill_q);
		end
	end

	assign out_valid = res_pend_q;
endmodule

// ===== sim/sws_checker.sv =====
// Checker for the sliding window statistics block: watches both channels,
// predicts each result from its own window model and compares. Uses sws_pkg.
module sws_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        action,
	input  logic signed [15:0] sample,
	input  logic [7:0]  sub_length,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic signed [15:0] average,
	input  logic signed [15:0] maximum,
	input  logic signed [15:0] minimum,
	input  logic [16:0] nonzero_fraction,
	input  logic signed [15:0] tail_average,
	input  logic        tail_valid,
	input  logic [4:0]  fill_level,
	output int          fail_count,
	output int          pending,
	output int          result_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import sws_pkg::*;

	localparam int WIN = 16;

	typedef struct packed {
		logic signed [15:0] avg;
		logic signed [15:0] mx;
		logic signed [15:0] mn;
		logic [16:0]        frac;
		logic signed [15:0] tail;
		logic               tvalid;
		logic [4:0]         fill;
	} stats_t;

	stats_t stats_q[$];
	int     slots[WIN];
	int     fill;

	function automatic int clip16(int x);
		if (x > 32767) return 32767;
		if (x < -32768) return -32768;
		return x;
	endfunction

	// Advance the window model by one transfer and build the expected stats
	function automatic stats_t window_step(logic act, logic signed [15:0] s,
			logic [7:0] len);
		stats_t r;
		int sum, mx, mn, nz, tsum;
		sum = 0; nz = 0; tsum = 0;
		if (action_t'(act) == ACT_CLEAR) begin
			foreach (slots[i]) slots[i] = 0;
			fill = 0;
		end else begin
			for (int i = 0; i < WIN - 1; i++) slots[i] = slots[i+1];
			slots[WIN-1] = s;
			if (fill < WIN) fill++;
		end
		mx = slots[0]; mn = slots[0];
		foreach (slots[i]) begin
			sum += slots[i];
			if (slots[i] > mx) mx = slots[i];
			if (slots[i] < mn) mn = slots[i];
			if (slots[i] != 0) nz++;
		end
		r.avg = (fill != 0) ? 16'(clip16(sum / fill)) : '0;
		r.mx = 16'(mx); r.mn = 16'(mn);
		r.frac = 17'((nz * 65536) / WIN);
		r.tvalid = (len >= 1 && len <= WIN);
		r.tail = '0;
		if (r.tvalid) begin
			for (int k = 0; k < len; k++) tsum += slots[WIN-1-k];
			r.tail = 16'(clip16(tsum / int'(len)));
		end
		r.fill = 5'(fill);
		return r;
	endfunction

	assign pending = stats_q.size();

	initial begin
		fail_count = 0;
		result_count = 0;
		foreach (slots[i]) slots[i] = 0;
		fill = 0;
	end

	// Input transfers feed the model; output transfers are compared in order
	always @(posedge clk) begin
		stats_t e, got;
		if (arst_n) begin
			if (in_valid && in_ready)
				stats_q.push_back(window_step(action, sample, sub_length));
			if (out_valid && out_ready) begin
				result_count++;
				got = '{average, maximum, minimum, nonzero_fraction,
					tail_average, tail_valid, fill_level};
				if (stats_q.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, got);
					fail_count++;
				end else begin
					e = stats_q.pop_front();
					if (got !== e) begin
						$display("%0t: expected avg %0d max %0d min %0d frac %0d tail %0d tv %0d fill %0d",
							$realtime, e.avg, e.mx, e.mn, e.frac, e.tail, e.tvalid, e.fill);
						$display("%0t: actual   avg %0d max %0d min %0d frac %0d tail %0d tv %0d fill %0d",
							$realtime, got.avg, got.mx, got.mn, got.frac, got.tail,
							got.tvalid, got.fill);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// ===== sim/testbench.sv =====
// Top of the sliding window statistics testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on sws_pkg, sws_checker and the block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sws_pkg::*;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic action = 0;
	logic signed [15:0] sample = 0;
	logic [7:0] sub_length = 0;
	logic signed [15:0] average, maximum, minimum, tail_average;
	logic [16:0] nonzero_fraction;
	logic tail_valid;
	logic [4:0] fill_level;
	int fail_count, pending, result_count;
	int cycles = 0, sent = 0;
	bit stim_done = 0;
	localparam int CYCLE_LIMIT = 2000000;

	always #1 clk = ~clk;

	sliding_window_statistics dut (.*);
	sws_checker chk (.*);

	// Gap length: mostly short, sometimes long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 90);
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 0;
			3: return 16'($urandom_range(0, 15) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_len();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 16;
			2: return 8'($urandom_range(17, 255));
			default: return 8'($urandom_range(1, 16));
		endcase
	endfunction

	// One input transfer, driven at the falling edge; valid drops only in a gap
	task automatic send(logic act, logic signed [15:0] s, logic [7:0] len, bit gaps);
		int g;
		g = gaps ? pick_gap() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1; action <= act; sample <= s; sub_length <= len;
		do @(posedge clk); while (!in_ready);
		sent++;
		@(negedge clk);
	endtask

	// Receiver: one long hold-off early on, then random stalls
	initial begin
		int g;
		@(posedge arst_n);
		@(negedge clk);
		out_ready <= 1;
		wait (sent >= 30);
		@(negedge clk);
		out_ready <= 0;
		repeat (400) @(negedge clk);
		forever begin
			out_ready <= 1;
			@(negedge clk);
			if ($urandom_range(0, 2) == 0) begin
				g = pick_gap();
				if (g > 0) begin
					out_ready <= 0;
					repeat (g) @(negedge clk);
				end
			end
		end
	end

	// Timeout watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sliding_window_statistics: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Directed: empty window, extremes, clears, tail edges
		send(ACT_PUSH, 16'sh7fff, 8'd1, 0);
		send(ACT_PUSH, 16'sh8000, 8'd2, 0);
		send(ACT_PUSH, 16'sh0000, 8'd0, 0);
		send(ACT_PUSH, 16'sh7fff, 8'd16, 0);
		send(ACT_PUSH, -16'sd1, 8'd17, 0);
		send(ACT_PUSH, 16'sh5555, 8'd255, 0);
		send(ACT_CLEAR, 16'shffff, 8'd16, 0);
		send(ACT_CLEAR, 16'sh1234, 8'd0, 0);
		for (int i = 0; i < 17; i++)
			send(ACT_PUSH, (i & 1) ? 16'sh8000 : 16'sh7fff, i[7:0], 0);
		// Random: mostly pushes, clears now and then, long bursts without gaps
		for (int i = 0; i < 1350; i++)
			send($urandom_range(0, 24) == 0, pick_sample(), pick_len(),
				(i % 300) > 60);
		in_valid <= 0;
		stim_done = 1;
		wait (pending == 0);
		repeat (100) @(posedge clk);
		$display("Sent %0d transfers (pushes, clears, tail lengths 0..255), %0d results checked.",
			sent, result_count);
		if (fail_count == 0 && pending == 0)
			$display("sliding_window_statistics: match");
		else
			$display("sliding_window_statistics: mismatch");
		$finish;
	end
endmodule

// ===== sliding_window_statistics.f =====
hdl/sws_pkg.sv
hdl/sws_cell.sv
hdl/sws_div.sv
hdl/sliding_window_statistics.sv
sim/sws_checker.sv
sim/testbench.sv
